// File: rtl/ghds_pkg.sv
// Shared types, codes and constants for the graph hop distance search unit.
// Used by ghds_front, ghds_back and the top level; depends on nothing.
package ghds_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int FIELD_W          = 5;
    localparam int COUNT_W          = 6;
    localparam logic [COUNT_W-1:0] VCOUNT_RESET = 6'd32;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_SEARCH,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind            kind;
        logic                 src_ok;
        logic [FIELD_W-1:0]   idx_a;
        logic [FIELD_W-1:0]   idx_b;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_B,
        S_SCAN,
        S_LEVEL,
        S_EMIT
    } t_state;

    function automatic int vert_limit(input int max_vertices);
        return (max_vertices < 32) ? max_vertices : 32;
    endfunction

    function automatic int index_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// File: rtl/ghds_front.sv
// Front end: accepts input words, drops words that change nothing and queues
// the rest as commands for the back end. Depends on ghds_pkg.
module ghds_front #(
    parameter int MAX_VERTICES = ghds_pkg::MAX_VERTICES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_operation,
    input  logic [ghds_pkg::FIELD_W-1:0]  i_edge_from,
    input  logic [ghds_pkg::FIELD_W-1:0]  i_edge_to,
    input  logic [ghds_pkg::FIELD_W-1:0]  i_start_vertex,
    output logic                          o_cmd_valid,
    output ghds_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_pop
);

    localparam int VL = ghds_pkg::vert_limit(MAX_VERTICES);
    localparam int QD = ghds_pkg::QDEPTH;
    localparam int PW = ghds_pkg::QPTR_W;
    localparam int CW = PW + 1;
    localparam logic [ghds_pkg::COUNT_W-1:0] VL_C = ghds_pkg::COUNT_W'(VL);

    ghds_pkg::t_cmd r_q [QD];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    ghds_pkg::t_cmd in_cmd;
    logic           keep;
    logic           accept;
    logic           enq;
    logic           deq;

    always_comb begin
        in_cmd        = '0;
        in_cmd.kind   = ghds_pkg::CMD_CLEAR;
        in_cmd.idx_a  = i_edge_from;
        in_cmd.idx_b  = i_edge_to;
        in_cmd.src_ok = 1'b0;
        keep          = 1'b0;
        unique case (i_operation)
            ghds_pkg::OP_ADD: begin
                in_cmd.kind = ghds_pkg::CMD_ADD;
                keep = ({1'b0, i_edge_from} < VL_C) && ({1'b0, i_edge_to} < VL_C);
            end
            ghds_pkg::OP_SEARCH: begin
                in_cmd.kind   = ghds_pkg::CMD_SEARCH;
                in_cmd.idx_a  = i_start_vertex;
                in_cmd.src_ok = ({1'b0, i_start_vertex} < VL_C);
                keep          = 1'b1;
            end
            ghds_pkg::OP_CLEAR: begin
                in_cmd.kind = ghds_pkg::CMD_CLEAR;
                keep        = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign full        = (r_cnt == CW'(QD));
    assign accept      = push && !full;
    assign enq         = accept && keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign deq         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wp <= (r_wp == PW'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (deq) begin
                r_rp <= (r_rp == PW'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            if (enq && !deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (deq && !enq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= in_cmd;
        end
    end

endmodule

// File: rtl/ghds_back.sv
// Back end: holds the adjacency matrix and the vertex count register, runs
// level-by-level searches and registers each result word. Depends on ghds_pkg.
module ghds_back #(
    parameter int MAX_VERTICES = ghds_pkg::MAX_VERTICES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ghds_pkg::COUNT_W-1:0]  i_cfg_wdata,
    input  logic                          i_cmd_valid,
    input  ghds_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [ghds_pkg::FIELD_W-1:0]  o_vertex,
    output logic [ghds_pkg::FIELD_W-1:0]  o_hop_distance,
    output logic                          o_reachable,
    output logic                          o_last
);

    localparam int VL = ghds_pkg::vert_limit(MAX_VERTICES);
    localparam int VW = ghds_pkg::index_width(VL);
    localparam int FW = ghds_pkg::FIELD_W;
    localparam int CNW = ghds_pkg::COUNT_W;
    localparam logic [FW-1:0] UNREACHED = FW'((MAX_VERTICES - 1) % 32);

    ghds_pkg::t_state r_state;
    ghds_pkg::t_state n_state;

    logic [CNW-1:0] r_vertex_count;
    logic [VL-1:0]  r_adj [VL];
    logic [VL-1:0]  r_row_ok;
    logic [VL-1:0]  r_rd_row;
    logic           r_rd_take;
    logic           r_rd_vld;
    logic [VW-1:0]  r_a;
    logic [VW-1:0]  r_b;
    logic [VW-1:0]  r_scan;
    logic [VW-1:0]  r_emit;
    logic [VW-1:0]  r_c_last;
    logic [FW-1:0]  r_level;
    logic [VL-1:0]  r_visited;
    logic [VL-1:0]  r_frontier;
    logic [VL-1:0]  r_acc;
    logic [FW-1:0]  r_dist [VL];
    logic           r_out_vld;
    logic [FW-1:0]  r_o_vertex;
    logic [FW-1:0]  r_o_hop;
    logic           r_o_reach;
    logic           r_o_last;

    logic [VW-1:0]  cmd_a;
    logic [VW-1:0]  cmd_b;
    logic [CNW-1:0] c_last_wide;
    logic [VW-1:0]  c_last_calc;
    logic [VL-1:0]  cmask;
    logic [VL-1:0]  acc_full;
    logic [VL-1:0]  new_set;
    logic           scan_last;
    logic           emit_last;
    logic           out_free;
    logic           wr_en;
    logic [VW-1:0]  wr_row;
    logic [VW-1:0]  wr_col;
    logic           start_search;
    logic           clear_all;
    logic           scan_on;
    logic           level_step;
    logic           emit_load;

    assign cmd_a = i_cmd.idx_a[VW-1:0];
    assign cmd_b = i_cmd.idx_b[VW-1:0];

    always_comb begin
        if (r_vertex_count == '0) begin
            c_last_wide = '0;
        end else if (r_vertex_count > CNW'(VL)) begin
            c_last_wide = CNW'(VL - 1);
        end else begin
            c_last_wide = r_vertex_count - 1'b1;
        end
        c_last_calc = c_last_wide[VW-1:0];
    end

    always_comb begin
        for (int i = 0; i < VL; i++) begin
            cmask[i] = (i <= int'(r_c_last));
        end
    end

    assign acc_full  = r_acc | ((r_rd_vld && r_rd_take) ? r_rd_row : '0);
    assign new_set   = acc_full & cmask & ~r_visited;
    assign scan_last = (r_scan == VW'(VL - 1));
    assign emit_last = (r_emit == r_c_last);
    assign out_free  = !r_out_vld || pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ghds_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        ghds_pkg::CMD_ADD:    n_state = ghds_pkg::S_ADD_B;
                        ghds_pkg::CMD_SEARCH: n_state = i_cmd.src_ok ? ghds_pkg::S_SCAN
                                                                     : ghds_pkg::S_EMIT;
                        default:              n_state = ghds_pkg::S_IDLE;
                    endcase
                end
            end
            ghds_pkg::S_ADD_B: n_state = ghds_pkg::S_IDLE;
            ghds_pkg::S_SCAN: begin
                if (scan_last) begin
                    n_state = ghds_pkg::S_LEVEL;
                end
            end
            ghds_pkg::S_LEVEL: begin
                n_state = (new_set == '0) ? ghds_pkg::S_EMIT : ghds_pkg::S_SCAN;
            end
            ghds_pkg::S_EMIT: begin
                if (out_free && emit_last) begin
                    n_state = ghds_pkg::S_IDLE;
                end
            end
            default: n_state = ghds_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop    = 1'b0;
        wr_en        = 1'b0;
        wr_row       = r_b;
        wr_col       = r_a;
        start_search = 1'b0;
        clear_all    = 1'b0;
        scan_on      = 1'b0;
        level_step   = 1'b0;
        emit_load    = 1'b0;
        unique case (r_state)
            ghds_pkg::S_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        ghds_pkg::CMD_ADD: begin
                            wr_en  = 1'b1;
                            wr_row = cmd_a;
                            wr_col = cmd_b;
                        end
                        ghds_pkg::CMD_SEARCH: start_search = 1'b1;
                        default:              clear_all    = 1'b1;
                    endcase
                end
            end
            ghds_pkg::S_ADD_B: wr_en      = 1'b1;
            ghds_pkg::S_SCAN:  scan_on    = 1'b1;
            ghds_pkg::S_LEVEL: level_step = 1'b1;
            ghds_pkg::S_EMIT:  emit_load  = out_free;
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ghds_pkg::S_IDLE;
            r_vertex_count <= ghds_pkg::VCOUNT_RESET;
            r_row_ok       <= '0;
            r_rd_vld       <= 1'b0;
            r_visited      <= '0;
            r_frontier     <= '0;
            r_out_vld      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= scan_on;
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_wdata;
            end
            if (clear_all) begin
                r_row_ok <= '0;
            end else if (wr_en) begin
                r_row_ok[wr_row] <= 1'b1;
            end
            if (start_search) begin
                r_visited  <= i_cmd.src_ok ? (VL'(1) << cmd_a) : '0;
                r_frontier <= i_cmd.src_ok ? (VL'(1) << cmd_a) : '0;
            end else if (level_step) begin
                r_visited  <= r_visited | new_set;
                r_frontier <= new_set;
            end
            if (emit_load) begin
                r_out_vld <= 1'b1;
            end else if (pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int j = 0; j < VL; j++) begin
                if (!r_row_ok[wr_row] || j == int'(wr_col)) begin
                    r_adj[wr_row][j] <= (j == int'(wr_col));
                end
            end
        end
        r_rd_row  <= r_adj[r_scan];
        r_rd_take <= r_row_ok[r_scan] && r_frontier[r_scan];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_a <= cmd_a;
            r_b <= cmd_b;
        end
        if (start_search) begin
            r_c_last <= c_last_calc;
            r_level  <= '0;
            r_acc    <= '0;
            r_scan   <= '0;
            r_emit   <= '0;
            if (i_cmd.src_ok) begin
                r_dist[cmd_a] <= '0;
            end
        end
        if (scan_on) begin
            r_scan <= r_scan + 1'b1;
            r_acc  <= acc_full;
        end
        if (level_step) begin
            r_acc   <= '0;
            r_scan  <= '0;
            r_level <= r_level + 1'b1;
            for (int i = 0; i < VL; i++) begin
                if (new_set[i]) begin
                    r_dist[i] <= r_level + 1'b1;
                end
            end
        end
        if (emit_load) begin
            r_emit     <= r_emit + 1'b1;
            r_o_vertex <= FW'(r_emit);
            r_o_hop    <= r_visited[r_emit] ? r_dist[r_emit] : UNREACHED;
            r_o_reach  <= r_visited[r_emit];
            r_o_last   <= emit_last;
        end
    end

    assign empty          = !r_out_vld;
    assign o_vertex       = r_o_vertex;
    assign o_hop_distance = r_o_hop;
    assign o_reachable    = r_o_reach;
    assign o_last         = r_o_last;

    a_frontier_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frontier & ~r_visited) == '0)
        else $error("Frontier holds a vertex that is not marked visited.");

    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ghds_pkg::S_SCAN || r_state == ghds_pkg::S_LEVEL) |-> !wr_en)
        else $error("Adjacency matrix written during a search.");

    a_last_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && emit_last) |=> (r_state == ghds_pkg::S_IDLE && !empty && o_last))
        else $error("Final result word did not close the search.");

    a_empty_level_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (level_step && new_set == '0) |=> (r_state == ghds_pkg::S_EMIT && r_emit == '0))
        else $error("Search did not move to reporting after an empty level.");

endmodule

// File: rtl/graph_hop_distance_search_unit.sv
// Top level of the graph hop distance search unit: front end queue plus
// search back end. Depends on ghds_pkg, ghds_front and ghds_back.
//
// Input words are pushed while full is low: add edge, search or clear graph.
// Add words whose endpoints fall outside the matrix and undefined codes are
// taken and dropped. The front end queues up to two commands, so input keeps
// flowing while the back end works. An add writes both matrix entries of the
// edge, in the dispatch state and in S_ADD_B. A search runs one level for
// every hop level plus one closing level; each level scans all VL rows, VL
// being the smaller of MAX_VERTICES and 32, one row per cycle through the
// single port of the adjacency matrix; a start vertex outside the matrix skips
// the levels. It then emits one result word per vertex in use, one per cycle
// while pop keeps up; the last word has o_last set. Results wait in an output
// register while empty is low, and a stalled receiver stalls only the back end.
// The vertex count register is written with i_cfg_we and takes effect at the
// next search. Reset empties the queue and the output, clears every edge
// through per-row valid bits and sets the vertex count to 32.
module graph_hop_distance_search_unit #(
    parameter int MAX_VERTICES = ghds_pkg::MAX_VERTICES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ghds_pkg::COUNT_W-1:0]  i_cfg_wdata,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_operation,
    input  logic [ghds_pkg::FIELD_W-1:0]  i_edge_from,
    input  logic [ghds_pkg::FIELD_W-1:0]  i_edge_to,
    input  logic [ghds_pkg::FIELD_W-1:0]  i_start_vertex,
    output logic                          empty,
    input  logic                          pop,
    output logic [ghds_pkg::FIELD_W-1:0]  o_vertex,
    output logic [ghds_pkg::FIELD_W-1:0]  o_hop_distance,
    output logic                          o_reachable,
    output logic                          o_last
);

    logic           cmd_valid;
    logic           cmd_pop;
    ghds_pkg::t_cmd cmd;

    ghds_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_edge_from    (i_edge_from),
        .i_edge_to      (i_edge_to),
        .i_start_vertex (i_start_vertex),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    ghds_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_pop      (cmd_pop),
        .empty          (empty),
        .pop            (pop),
        .o_vertex       (o_vertex),
        .o_hop_distance (o_hop_distance),
        .o_reachable    (o_reachable),
        .o_last         (o_last)
    );

endmodule
